// ===== sv/rpt_pkg.sv =====
// Shared definitions for the region protection table: field widths, request
// kinds, status codes and parameter defaults. No dependencies.
`default_nettype none
package rpt_pkg;

    localparam int KIND_W   = 2;
    localparam int PID_W    = 16;
    localparam int ADDR_W   = 32;
    localparam int RIGHTS_W = 3;
    localparam int STATUS_W = 3;

    localparam int REGION_COUNT_DEFAULT = 128;
    localparam int PAGE_SHIFT_DEFAULT   = 12;

    typedef enum logic [KIND_W-1:0] {
        KIND_PERMIT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CHECK  = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 3'd0,
        STATUS_INVALID  = 3'd1,
        STATUS_OVERLAP  = 3'd2,
        STATUS_FULL     = 3'd3,
        STATUS_NO_MATCH = 3'd4
    } status_t;

endpackage
`default_nettype wire

// ===== sv/rpt_req_if.sv =====
// Request channel of the region protection table: valid/ready handshake with
// the request payload. Depends on rpt_pkg.
`default_nettype none
interface rpt_req_if;
    import rpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [PID_W-1:0]    process_id;
    logic [ADDR_W-1:0]   start_address;
    logic [ADDR_W-1:0]   byte_count;
    logic [RIGHTS_W-1:0] access_rights;

    modport source (output valid, kind, process_id, start_address, byte_count,
                    access_rights, input ready);
    modport sink   (input valid, kind, process_id, start_address, byte_count,
                    access_rights, output ready);
endinterface
`default_nettype wire

// ===== sv/rpt_rsp_if.sv =====
// Response channel of the region protection table: valid/ready handshake with
// the status and grant flag. Depends on rpt_pkg.
`default_nettype none
interface rpt_rsp_if;
    import rpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                granted;

    modport source (output valid, status, granted, input ready);
    modport sink   (input valid, status, granted, output ready);
endinterface
`default_nettype wire

// ===== sv/region_protection_table.sv =====
// Region protection table top level: request decoder, region memory with its
// scan sequencer, and the response register. Depends on rpt_pkg, rpt_req_if, rpt_rsp_if.
//
// Each request transaction is a permit, remove, check or clear for a process and a byte
// range, which is widened outward to page boundaries. One transaction is processed at a
// time: the idle state takes it, the prepare state widens and validates the range, then a
// scan of the region memory reads one entry per cycle through its single read port, and
// the done state, once the response register is free, updates the table and loads that
// register. A clear or an invalid request skips the scan, and a scan stops early at the
// first overlapping, matching or covering region. The response register lets a new
// request be taken while the previous response still waits to be collected. The valid
// flags sit in flip-flops and are cleared at reset and by a clear request, so no clearing
// pass over the memory is needed.
`default_nettype none
module region_protection_table #(
    parameter int REGION_COUNT = rpt_pkg::REGION_COUNT_DEFAULT,
    parameter int PAGE_SHIFT   = rpt_pkg::PAGE_SHIFT_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rpt_req_if.sink    req,
    rpt_rsp_if.source  rsp
);
    import rpt_pkg::*;

    // Addresses are held as page numbers; a widened end never exceeds the last page
    // boundary below 4 GiB, so both ends fit in the same width.
    localparam int PW   = ADDR_W - PAGE_SHIFT;
    localparam int IDXW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int CW   = $clog2(REGION_COUNT + 1);

    typedef struct packed {
        logic [PW-1:0]       base;
        logic [PW-1:0]       limit;
        logic [PID_W-1:0]    pid;
        logic [RIGHTS_W-1:0] rights;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Captured request (payload, no reset).
    kind_t               kind_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   count_reg;
    logic [RIGHTS_W-1:0] rights_reg;

    // Widened range and the validity verdict.
    logic [PW-1:0] base_reg;
    logic [PW-1:0] limit_reg;
    logic          bad_reg;

    // Region storage and valid flags.
    entry_t                  mem [REGION_COUNT];
    entry_t                  rd_data_reg;
    logic [REGION_COUNT-1:0] valid_reg, valid_next;

    // Scan sequencer.
    logic [CW-1:0]   iss_cnt_reg, iss_cnt_next;
    logic [IDXW-1:0] iss_idx;
    logic            issue;
    logic            pipe_v_reg, pipe_v_next;
    logic [IDXW-1:0] pipe_idx_reg;
    logic            pipe_ev_reg;
    logic            hit_reg, hit_next;
    logic [IDXW-1:0] hit_idx_reg;
    logic            free_found_reg, free_found_next;
    logic [IDXW-1:0] free_idx_reg;
    logic            cmp_hit;
    logic            stop;

    // Response register.
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                rsp_granted_reg;
    status_t             status_calc;
    logic                granted_calc;
    logic                out_free;
    logic                finish;
    logic                mem_we;

    // Range widening terms.
    logic [ADDR_W:0]   end_byte;
    logic [PW:0]       end_page;
    logic              range_bad;

    logic in_take;

    assign in_take   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // The exclusive end must stay within 32 bits, and so must the end rounded up
    // to a page boundary.
    always_comb
    begin
        end_byte  = {1'b0, addr_reg} + {1'b0, count_reg};
        end_page  = {1'b0, end_byte[ADDR_W-1:PAGE_SHIFT]}
                    + {{PW{1'b0}}, |end_byte[PAGE_SHIFT-1:0]};
        range_bad = (count_reg == '0) || end_byte[ADDR_W] || end_page[PW];
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= kind_t'(req.kind);
            pid_reg    <= req.process_id;
            addr_reg   <= req.start_address;
            count_reg  <= req.byte_count;
            rights_reg <= req.access_rights;
        end
        if (state_reg == ST_PREP)
        begin
            base_reg  <= addr_reg[ADDR_W-1:PAGE_SHIFT];
            limit_reg <= end_page[PW-1:0];
            bad_reg   <= (kind_reg != KIND_CLEAR)
                         && ((pid_reg == '0) || range_bad
                             || ((kind_reg == KIND_PERMIT) && (rights_reg == '0)));
        end
    end

    // Compare stage: the entry read in the previous cycle against the request.
    always_comb
    begin
        cmp_hit = 1'b0;
        if (pipe_v_reg && pipe_ev_reg && (rd_data_reg.pid == pid_reg))
        begin
            case (kind_reg)
                KIND_PERMIT:
                    cmp_hit = (base_reg < rd_data_reg.limit) && (rd_data_reg.base < limit_reg);
                KIND_REMOVE:
                    cmp_hit = (base_reg == rd_data_reg.base) && (limit_reg == rd_data_reg.limit);
                KIND_CHECK:
                    cmp_hit = (base_reg >= rd_data_reg.base) && (limit_reg <= rd_data_reg.limit)
                              && ((rights_reg & rd_data_reg.rights) == rights_reg);
                default:
                    cmp_hit = 1'b0;
            endcase
        end
    end

    assign stop    = (state_reg == ST_SCAN) && cmp_hit;
    assign iss_idx = iss_cnt_reg[IDXW-1:0];
    assign issue   = (state_reg == ST_SCAN) && (iss_cnt_reg < CW'(REGION_COUNT)) && !stop;

    // Result of the finished request.
    always_comb
    begin
        status_calc  = STATUS_DONE;
        granted_calc = 1'b0;
        if (kind_reg == KIND_CLEAR)
        begin
            status_calc = STATUS_DONE;
        end
        else if (bad_reg)
        begin
            status_calc = STATUS_INVALID;
        end
        else
        begin
            case (kind_reg)
                KIND_PERMIT:
                    status_calc = hit_reg ? STATUS_OVERLAP
                                : (free_found_reg ? STATUS_DONE : STATUS_FULL);
                KIND_REMOVE:
                    status_calc = hit_reg ? STATUS_DONE : STATUS_NO_MATCH;
                KIND_CHECK:
                begin
                    status_calc  = STATUS_DONE;
                    granted_calc = hit_reg;
                end
                default:
                    status_calc = STATUS_DONE;
            endcase
        end
    end

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign finish   = (state_reg == ST_DONE) && out_free;
    assign mem_we   = finish && (kind_reg == KIND_PERMIT) && !bad_reg && !hit_reg
                      && free_found_reg;

    always_comb
    begin
        state_next      = state_reg;
        iss_cnt_next    = iss_cnt_reg;
        pipe_v_next     = issue;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                iss_cnt_next    = '0;
                hit_next        = 1'b0;
                free_found_next = 1'b0;
                if ((kind_reg == KIND_CLEAR) || (pid_reg == '0) || range_bad
                    || ((kind_reg == KIND_PERMIT) && (rights_reg == '0)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    iss_cnt_next = iss_cnt_reg + CW'(1);
                end
                if (pipe_v_reg && !pipe_ev_reg && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                end
                if (stop)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!issue && !pipe_v_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (kind_reg == KIND_CLEAR)
                    begin
                        valid_next = '0;
                    end
                    else if (mem_we)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    else if ((kind_reg == KIND_REMOVE) && !bad_reg && hit_reg)
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iss_cnt_reg    <= '0;
            pipe_v_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iss_cnt_reg    <= iss_cnt_next;
            pipe_v_reg     <= pipe_v_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Scan payload and response payload.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pipe_idx_reg <= iss_idx;
            pipe_ev_reg  <= valid_reg[iss_idx];
        end
        if (stop)
        begin
            hit_idx_reg <= pipe_idx_reg;
        end
        if ((state_reg == ST_SCAN) && pipe_v_reg && !pipe_ev_reg && !free_found_reg)
        begin
            free_idx_reg <= pipe_idx_reg;
        end
        if (finish)
        begin
            rsp_status_reg  <= status_calc;
            rsp_granted_reg <= granted_calc;
        end
    end

    // Region memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[free_idx_reg] <= '{base: base_reg, limit: limit_reg, pid: pid_reg,
                                   rights: rights_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[iss_idx];
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.granted = rsp_granted_reg;

    // A new region only ever lands in a free slot.
    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !valid_reg[free_idx_reg])
        else $error("permit wrote over a valid region");

    // A clear leaves no valid region behind.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (kind_reg == KIND_CLEAR)) |=> (valid_reg == '0))
        else $error("clear left valid regions");

    // A grant is only given with a done status.
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.granted) |-> (rsp.status == STATUS_DONE))
        else $error("grant reported with a failing status");

    // A remove that reports success has freed the matched slot.
    a_remove_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (kind_reg == KIND_REMOVE) && (status_calc == STATUS_DONE))
        |=> !valid_reg[$past(hit_idx_reg)])
        else $error("successful remove left the region valid");

    // The scan never issues a read beyond the last slot.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (iss_cnt_reg < CW'(REGION_COUNT)))
        else $error("scan read past the table");

endmodule
`default_nettype wire

// ===== bench/rpt_response_checker.sv =====
// Response checker for the region protection table: watches both channels, keeps its own
// copy of the region table and compares every response transaction with its prediction.
// Depends on rpt_pkg, rpt_req_if and rpt_rsp_if.
module rpt_response_checker #(
    parameter int REGION_COUNT = rpt_pkg::REGION_COUNT_DEFAULT,
    parameter int PAGE_SHIFT   = rpt_pkg::PAGE_SHIFT_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    rpt_req_if   req,
    rpt_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   checked,
    output int   full_seen,
    output int   grants_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    localparam logic [32:0] PAGE_MASK = (33'd1 << PAGE_SHIFT) - 33'd1;
    localparam logic [32:0] ADDR_TOP  = 33'h0_FFFF_FFFF;

    typedef struct {
        logic [32:0]         base;
        logic [32:0]         limit;
        logic [PID_W-1:0]    pid;
        logic [RIGHTS_W-1:0] rights;
    } region_t;

    typedef struct {
        status_t status;
        logic    granted;
    } reply_t;

    region_t regions [REGION_COUNT];
    bit      in_use  [REGION_COUNT];
    reply_t  predicted_replies [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Applies one request to the shadow table and returns the reply it should produce.
    function automatic reply_t apply_request(kind_t kind, logic [PID_W-1:0] pid,
                                             logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] count,
                                             logic [RIGHTS_W-1:0] rights);
        logic [32:0] stop;
        logic [32:0] base;
        logic [32:0] limit;
        bit          range_ok;
        int          free_slot;
        int          i;
        reply_t      r;
        r.status  = STATUS_DONE;
        r.granted = 1'b0;
        free_slot = -1;
        stop      = {1'b0, addr} + {1'b0, count};
        limit     = (stop + PAGE_MASK) & ~PAGE_MASK;
        base      = {1'b0, addr} & ~PAGE_MASK;
        range_ok  = (count != '0) && (stop <= ADDR_TOP) && (limit <= ADDR_TOP);
        if (kind == KIND_CLEAR) begin
            for (i = 0; i < REGION_COUNT; i++)
                in_use[i] = 1'b0;
        end
        else if (pid == '0 || !range_ok || (kind == KIND_PERMIT && rights == '0)) begin
            r.status = STATUS_INVALID;
        end
        else if (kind == KIND_PERMIT) begin
            for (i = 0; i < REGION_COUNT; i++) begin
                if (!in_use[i]) begin
                    if (free_slot < 0)
                        free_slot = i;
                end
                else if (regions[i].pid == pid && base < regions[i].limit
                         && regions[i].base < limit) begin
                    r.status = STATUS_OVERLAP;
                    break;
                end
            end
            if (r.status == STATUS_DONE) begin
                if (free_slot < 0) begin
                    r.status = STATUS_FULL;
                end
                else begin
                    regions[free_slot].base   = base;
                    regions[free_slot].limit  = limit;
                    regions[free_slot].pid    = pid;
                    regions[free_slot].rights = rights;
                    in_use[free_slot]         = 1'b1;
                end
            end
        end
        else if (kind == KIND_REMOVE) begin
            r.status = STATUS_NO_MATCH;
            for (i = 0; i < REGION_COUNT; i++) begin
                if (in_use[i] && regions[i].pid == pid && regions[i].base == base
                    && regions[i].limit == limit) begin
                    in_use[i] = 1'b0;
                    r.status  = STATUS_DONE;
                    break;
                end
            end
        end
        else begin
            for (i = 0; i < REGION_COUNT; i++) begin
                if (in_use[i] && regions[i].pid == pid && base >= regions[i].base
                    && limit <= regions[i].limit && (rights & regions[i].rights) == rights) begin
                    r.granted = 1'b1;
                    break;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        reply_t want;
        if (!rst_n) begin
            for (int i = 0; i < REGION_COUNT; i++)
                in_use[i] = 1'b0;
            predicted_replies.delete();
            pending = 0;
        end
        else begin
            // A response accepted at the same edge as a request always belongs to an older
            // request, so pushing first and popping the oldest afterwards is safe.
            if (req.valid === 1'b1 && req.ready === 1'b1)
                predicted_replies.push_back(apply_request(kind_t'(req.kind), req.process_id,
                                                          req.start_address, req.byte_count,
                                                          req.access_rights));
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                checked++;
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                              checked));
                end
                else begin
                    want = predicted_replies.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("response %0d status %0d, expected %s",
                                                  checked, rsp.status, want.status.name()));
                    if (rsp.granted !== want.granted)
                        report_mismatch($sformatf("response %0d granted %b, expected %b",
                                                  checked, rsp.granted, want.granted));
                end
                if (rsp.status === STATUS_FULL)
                    full_seen++;
                if (rsp.granted === 1'b1)
                    grants_seen++;
            end
            pending = predicted_replies.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Top of the region protection table testbench: clock, reset, request and response
// stimulus, and the final verdict. Depends on rpt_pkg, the two channel interfaces,
// region_protection_table and rpt_response_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    // Length of the random part and the points at which the special pressure phases start.
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 700;
    // Within this window every request but a rare random clear is a permit, mostly for a fresh
    // process, so the table is expected to fill and the table-full answer is exercised.
    localparam int FILL_FROM    = 350;
    localparam int FILL_TO      = 500;
    // The tail wait is a little longer than a full scan of the table.
    localparam int TAIL_CYCLES  = 140;

    typedef struct {
        kind_t               kind;
        logic [PID_W-1:0]    pid;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   count;
        logic [RIGHTS_W-1:0] rights;
    } request_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int grants_seen;

    request_t permit_history [$];
    int       kind_sent [4];
    bit       hold_request;
    int       burst_left;

    always #1 clk = ~clk;

    rpt_req_if req_ch ();
    rpt_rsp_if rsp_ch ();

    region_protection_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rpt_response_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .full_seen   (full_seen),
        .grants_seen (grants_seen)
    );

    function automatic request_t make_request(kind_t kind, logic [PID_W-1:0] pid,
                                              logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] count,
                                              logic [RIGHTS_W-1:0] rights);
        request_t it;
        it.kind   = kind;
        it.pid    = pid;
        it.addr   = addr;
        it.count  = count;
        it.rights = rights;
        return it;
    endfunction

    // Builds the next random request. Most are well formed: permits, and removes and checks
    // that refer back to regions permitted earlier, so that removes find exact matches and
    // checks land inside real regions; the rest is noise with random fields, or a clear.
    function automatic request_t next_request(int n);
        request_t          it;
        request_t          h;
        int                pick;
        logic [19:0]       page;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] count;
        pick = $urandom_range(0, 99);
        if (n == 600 || n == 1000 || $urandom_range(0, 199) == 0)
            return make_request(KIND_CLEAR, PID_W'($urandom), $urandom, $urandom,
                                RIGHTS_W'($urandom));
        if (pick < 12 && !(n >= FILL_FROM && n < FILL_TO))
            return make_request(kind_t'($urandom_range(0, 2)), PID_W'($urandom), $urandom,
                                $urandom, RIGHTS_W'($urandom));
        if ((n >= FILL_FROM && n < FILL_TO) || pick < 55 || permit_history.size() == 0)
        begin
            // Mostly low pages, so that regions of the same process collide now and then;
            // occasionally anywhere in the address space, the top pages included.
            page   = ($urandom_range(0, 4) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                                 : 20'($urandom_range(0, 63));
            offset = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom_range(0, 4095)) : '0;
            count  = ADDR_W'($urandom_range(1, 3)) << 12;
            if ($urandom_range(0, 3) == 0)
                count = count - ADDR_W'($urandom_range(1, 4095));
            it = make_request(KIND_PERMIT,
                              (n >= FILL_FROM && n < FILL_TO) ? PID_W'($urandom_range(100, 65535))
                                                              : PID_W'($urandom_range(1, 12)),
                              {page, 12'h000} | offset, count, RIGHTS_W'($urandom_range(1, 7)));
            permit_history.push_back(it);
            if (permit_history.size() > 64)
                void'(permit_history.pop_front());
            return it;
        end
        h = permit_history[$urandom_range(0, permit_history.size() - 1)];
        it = h;
        if (pick < 70)
        begin
            it.kind   = KIND_REMOVE;
            it.rights = RIGHTS_W'($urandom);
            if ($urandom_range(0, 4) == 0)
                it.pid = h.pid + 1'b1;
        end
        else
        begin
            it.kind   = KIND_CHECK;
            it.addr   = h.addr + ADDR_W'($urandom_range(0, h.count >> 1));
            it.count  = ADDR_W'($urandom_range(1, h.count));
            it.rights = ($urandom_range(0, 1) == 0) ? (h.rights & RIGHTS_W'($urandom))
                                                    : RIGHTS_W'($urandom);
            if ($urandom_range(0, 9) == 0)
                it.pid = PID_W'($urandom_range(1, 12));
        end
        return it;
    endfunction

    // Offers one request transaction from the falling edge on and returns once it has been
    // accepted at a rising edge. The next call reasserts valid at the following falling
    // edge, so valid is never dropped and raised in the same step.
    task automatic send_request(input request_t it);
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= it.kind;
        req_ch.process_id    <= it.pid;
        req_ch.start_address <= it.addr;
        req_ch.byte_count    <= it.count;
        req_ch.access_rights <= it.rights;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        kind_sent[it.kind]++;
    endtask

    // The sender works in bursts. At the end of each burst it may go quiet for a while; the
    // gaps are long enough to land anywhere in the block's scan of the table.
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 160);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // Request side: reset, the directed requests, then the random stream.
    initial
    begin
        request_t directed [$];
        request_t it;
        req_ch.valid         = 1'b0;
        req_ch.kind          = KIND_PERMIT;
        req_ch.process_id    = '0;
        req_ch.start_address = '0;
        req_ch.byte_count    = '0;
        req_ch.access_rights = '0;
        burst_left           = 1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: the invalid cases, the edges of the address space, overlap with the
        // same and with another process, covering and non-covering checks, checks with no
        // rights, exact and inexact removes, and clearing the table.
        directed.push_back(make_request(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'h7));
        directed.push_back(make_request(KIND_PERMIT, 16'h0000, 32'h0000_1000, 32'h0000_1000, 3'h7));
        directed.push_back(make_request(KIND_PERMIT, 16'h0001, 32'h0000_1000, 32'h0000_0000, 3'h7));
        directed.push_back(make_request(KIND_PERMIT, 16'h0001, 32'h0000_1000, 32'h0000_1000, 3'h0));
        // The exclusive end runs past the top of the address space.
        directed.push_back(make_request(KIND_PERMIT, 16'h0001, 32'hFFFF_FFFF, 32'h0000_0001, 3'h7));
        // The end fits, but rounding it up to a page boundary does not.
        directed.push_back(make_request(KIND_PERMIT, 16'h0001, 32'hFFFF_F001, 32'h0000_0FFE, 3'h7));
        directed.push_back(make_request(KIND_PERMIT, 16'hFFFF, 32'hFFFF_E000, 32'h0000_1000, 3'h7));
        directed.push_back(make_request(KIND_PERMIT, 16'h0001, 32'h0000_1234, 32'h0000_0010, 3'h3));
        directed.push_back(make_request(KIND_PERMIT, 16'h0001, 32'h0000_1800, 32'h0000_1000, 3'h1));
        directed.push_back(make_request(KIND_PERMIT, 16'h0002, 32'h0000_1800, 32'h0000_1000, 3'h1));
        directed.push_back(make_request(KIND_CHECK, 16'h0001, 32'h0000_1000, 32'h0000_1000, 3'h3));
        directed.push_back(make_request(KIND_CHECK, 16'h0001, 32'h0000_1000, 32'h0000_1000, 3'h4));
        directed.push_back(make_request(KIND_CHECK, 16'h0001, 32'h0000_1FFF, 32'h0000_0001, 3'h0));
        directed.push_back(make_request(KIND_CHECK, 16'h0001, 32'h0000_1800, 32'h0000_1000, 3'h1));
        directed.push_back(make_request(KIND_CHECK, 16'h0000, 32'h0000_1000, 32'h0000_1000, 3'h1));
        directed.push_back(make_request(KIND_REMOVE, 16'h0001, 32'h0000_1000, 32'h0000_2000, 3'h0));
        directed.push_back(make_request(KIND_REMOVE, 16'h0001, 32'h0000_1FFF, 32'h0000_0001, 3'h5));
        directed.push_back(make_request(KIND_REMOVE, 16'h0001, 32'h0000_1000, 32'h0000_1000, 3'h0));
        directed.push_back(make_request(KIND_CHECK, 16'h0001, 32'h0000_1000, 32'h0000_1000, 3'h1));
        directed.push_back(make_request(KIND_REMOVE, 16'h0002, 32'h0000_1000, 32'h0000_0000, 3'h0));
        directed.push_back(make_request(KIND_CHECK, 16'h0003, 32'h0000_0000, 32'hFFFF_FFFF, 3'h1));
        directed.push_back(make_request(KIND_PERMIT, 16'h0003, 32'h0000_0000, 32'hFFFF_F000, 3'h7));
        directed.push_back(make_request(KIND_CHECK, 16'h0003, 32'h0000_0000, 32'hFFFF_F000, 3'h7));
        directed.push_back(make_request(KIND_CLEAR, 16'h0000, 32'h0000_0000, 32'h0000_0000, 3'h0));
        directed.push_back(make_request(KIND_CHECK, 16'h0003, 32'h0000_0000, 32'h0000_1000, 3'h0));
        foreach (directed[i])
        begin
            send_request(directed[i]);
            pace();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            it = next_request(n);
            send_request(it);
            // Ask the receiver for its long hold-off; the sender carries on offering, so the
            // block fills its response register, takes the next request up to done and stalls input.
            if (n == HOLD_AT)
                hold_request = 1'b1;
            if (n == DRAIN_AT)
            begin
                // Let the block drain completely before the stream resumes.
                @(negedge clk);
                req_ch.valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            else
            begin
                pace();
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // Anything arriving after this point has no prediction and is flagged by the checker.
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d requests: %0d permit, %0d remove, %0d check, %0d clear.",
                 kind_sent[KIND_PERMIT] + kind_sent[KIND_REMOVE] + kind_sent[KIND_CHECK]
                 + kind_sent[KIND_CLEAR], kind_sent[KIND_PERMIT], kind_sent[KIND_REMOVE],
                 kind_sent[KIND_CHECK], kind_sent[KIND_CLEAR]);
        $display("%0d responses compared, %0d with the table full, %0d checks granted.",
                 checked, full_seen, grants_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Response side: ready follows a pattern of its own, with stretches of random stalls,
    // long stretches without any stall, and the one long hold-off the sender asks for.
    initial
    begin
        int len;
        bit level;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= 1'b0;
                end
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    level = 1'b1;
                    len   = $urandom_range(200, 400);
                end
                else
                begin
                    level = ($urandom_range(0, 9) < 7);
                    len   = level ? $urandom_range(1, 40) : $urandom_range(1, 30);
                end
                repeat (len)
                begin
                    @(negedge clk);
                    rsp_ch.ready <= level;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run, including every stall and gap.
    initial
    begin
        #10_000_000;
        $display("ERROR: run timed out with %0d responses outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== region_protection_table.f =====
sv/rpt_pkg.sv
sv/rpt_req_if.sv
sv/rpt_rsp_if.sv
sv/region_protection_table.sv
bench/rpt_response_checker.sv
bench/tb.sv
